@@ rtl/cdq_pkg.sv @@
`default_nettype none
package cdq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 5;
  localparam int CAP_W   = 5;
  localparam int ACT_W   = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_BACK  = 3'd3,
    ACT_PEEK      = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_DEL_FRONT,
    OP_DEL_BACK,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [CNT_W-1:0]         occupancy;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/cdq_cell.sv @@
`default_nettype none
module cdq_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cdq_pkg::cell_op_t             op,
  input  wire logic [cdq_pkg::DATA_W-1:0]    ins_value,
  input  wire logic [cdq_pkg::DATA_W-1:0]    left_data,
  input  wire logic                          left_valid,
  input  wire logic [cdq_pkg::DATA_W-1:0]    right_data,
  input  wire logic                          right_valid,
  output logic [cdq_pkg::DATA_W-1:0]         data,
  output logic                               valid
);

  logic [cdq_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                       valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (op)
      cdq_pkg::OP_INS_FRONT: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      cdq_pkg::OP_INS_BACK: begin
        // the first empty cell takes the new element
        if (!valid_r && left_valid) begin
          data_nxt  = ins_value;
          valid_nxt = 1'b1;
        end
      end
      cdq_pkg::OP_DEL_FRONT: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      cdq_pkg::OP_DEL_BACK: begin
        valid_nxt = right_valid;
      end
      cdq_pkg::OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
        data_nxt  = data_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

@@ rtl/circular_double_ended_queue.sv @@
`default_nettype none
// Double-ended queue of up to 16 signed 32-bit elements, held front-first in a
// row of cells that shift as a whole on front inserts and deletes. One command
// is taken per clock (busy stays low) unless cfg_we is set; its result appears
// on out_item with out_valid high for exactly one cycle, the cycle after
// start; the receiver cannot stall it. A write to the capacity register
// empties the queue; capacity 0 acts as 1 and values above 16 act as 16.
module circular_double_ended_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire cdq_pkg::in_item_t           in_item,
  output logic                             out_valid,
  output cdq_pkg::out_item_t               out_item,
  input  wire logic                        cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int D = cdq_pkg::DEPTH;

  logic [cdq_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic [cdq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accepted_r, accepted_nxt;
  logic [cdq_pkg::CAP_W-1:0]  eff_cap;
  logic                       full, empty;
  cdq_pkg::cell_op_t          op;

  logic [cdq_pkg::DATA_W-1:0] cell_data  [D];
  logic                       cell_valid [D];
  logic [D-1:0]               rear_hit;
  logic [cdq_pkg::DATA_W-1:0] rear_data;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = cdq_pkg::CAP_W'(1);
    end else if (cap_r > cdq_pkg::CAP_W'(D)) begin
      eff_cap = cdq_pkg::CAP_W'(D);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign full  = count_r >= cdq_pkg::CNT_W'(eff_cap);
  assign empty = count_r == '0;

  always_comb begin
    op            = cdq_pkg::OP_HOLD;
    count_nxt     = count_r;
    accepted_nxt  = accepted_r;
    out_valid_nxt = 1'b0;
    cap_nxt       = cap_r;
    if (cfg_we) begin
      cap_nxt   = cfg_wdata;
      op        = cdq_pkg::OP_CLEAR;
      count_nxt = '0;
    end else if (start) begin
      out_valid_nxt = 1'b1;
      accepted_nxt  = 1'b0;
      case (in_item.action)
        cdq_pkg::ACT_INS_FRONT: begin
          if (!full) begin
            op           = cdq_pkg::OP_INS_FRONT;
            count_nxt    = count_r + cdq_pkg::CNT_W'(1);
            accepted_nxt = 1'b1;
          end
        end
        cdq_pkg::ACT_INS_BACK: begin
          if (!full) begin
            op           = cdq_pkg::OP_INS_BACK;
            count_nxt    = count_r + cdq_pkg::CNT_W'(1);
            accepted_nxt = 1'b1;
          end
        end
        cdq_pkg::ACT_DEL_FRONT: begin
          if (!empty) begin
            op           = cdq_pkg::OP_DEL_FRONT;
            count_nxt    = count_r - cdq_pkg::CNT_W'(1);
            accepted_nxt = 1'b1;
          end
        end
        cdq_pkg::ACT_DEL_BACK: begin
          if (!empty) begin
            op           = cdq_pkg::OP_DEL_BACK;
            count_nxt    = count_r - cdq_pkg::CNT_W'(1);
            accepted_nxt = 1'b1;
          end
        end
        cdq_pkg::ACT_PEEK: begin
          accepted_nxt = 1'b1;
        end
        default: begin
          accepted_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= cdq_pkg::CAP_W'(D);
      count_r     <= '0;
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      accepted_r  <= accepted_nxt;
    end
  end

  // cell 0 holds the front; data moves up on front insert, down on front delete
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [cdq_pkg::DATA_W-1:0] l_data, r_data;
    logic                       l_valid, r_valid;
    if (i == 0) begin : g_first
      assign l_data  = in_item.value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == D-1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    // last occupied cell
    assign rear_hit[i] = cell_valid[i] & ~r_valid;

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .ins_value   (in_item.value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i])
    );
  end

  // rear is the last occupied cell: one-hot and-or over the row
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < D; i++) begin
      if (rear_hit[i]) begin
        rear_data = rear_data | cell_data[i];
      end
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;

  always_comb begin
    out_item.accepted    = accepted_r;
    out_item.front_value = empty ? '1 : cell_data[0];
    out_item.rear_value  = empty ? '1 : rear_data;
    out_item.is_empty    = empty;
    out_item.is_full     = full;
    out_item.occupancy   = count_r;
  end

endmodule
`default_nettype wire
